// ===== rtl/bpq_pkg.sv =====
// Shared types and constants for the button press qualifier.
package bpq_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEBOUNCE_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_LONG_PRESS_TIME   = 2'd1;
    localparam logic [1:0] CFG_MAX_COUNT         = 2'd2;

    // Configuration reset values
    localparam logic [7:0]  DEBOUNCE_RESET   = 8'd50;
    localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;
    localparam logic [7:0]  MAX_COUNT_RESET  = 8'd10;

    // Timer ceilings
    localparam logic [8:0]  SINCE_MAX = 9'h1FF;
    localparam logic [16:0] HELD_MAX  = 17'h1FFFF;

    // Pin levels (active-low button)
    localparam logic LEVEL_PRESSED  = 1'b0;
    localparam logic LEVEL_RELEASED = 1'b1;

    typedef struct packed {
        logic [7:0]  debounce_interval;
        logic [15:0] long_press_time;
        logic [7:0]  max_count;
    } t_cfg;

    typedef struct packed {
        logic [7:0] press_count;
        logic       long_flag;
        logic       logic_flag;
        logic       debounced_level;
    } t_result;

endpackage

// ===== rtl/button_press_qualifier_core.sv =====
// Pipeline: input register, then result register, between input request and result.
// Throughput: one tick per cycle; the result register stalls only when the sink does.
// The result register frees its slot in the same cycle the sink takes the result.
// Reset: synchronous active-low; clears the valid flags of both pipeline registers, the
// debounce and press state, and loads the configuration registers with their default values.
module button_press_qualifier_core
    import bpq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] pin_level, [7:1] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] debounced_level, [1] logic_flag,
                                        // [2] long_flag, [10:3] press_count, [15:11] zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_result tick_result;
    t_result r_out;
    logic    r_in_valid;
    logic    r_in_pin;
    logic    r_out_valid;
    logic    advance;

    // Configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_interval <= DEBOUNCE_RESET;
            r_cfg.long_press_time   <= LONG_PRESS_RESET;
            r_cfg.max_count         <= MAX_COUNT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEBOUNCE_INTERVAL: r_cfg.debounce_interval <= i_cfg_data[7:0];
                CFG_LONG_PRESS_TIME:   r_cfg.long_press_time   <= i_cfg_data;
                CFG_MAX_COUNT:         r_cfg.max_count         <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Move a request forward whenever the result register has room
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_pin <= s_axis_tdata[0];
        end
    end

    bpq_tick u_tick (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (r_in_valid && advance),
        .i_pin    (r_in_pin),
        .i_cfg    (r_cfg),
        .o_result (tick_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out <= tick_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out.press_count, r_out.long_flag,
                            r_out.logic_flag, r_out.debounced_level};

    // A tick that moves forward always lands in the result register
    a_tick_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && advance |=> r_out_valid)
        else $error("tick advanced but result register is empty");

    // The input side only stalls while a tick is held in the input register and the sink blocks the result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid && r_out_valid && !m_axis_tready)
        else $error("input stalled without a blocked tick");

    // A loaded result carries the press count the tick logic produced
    a_count_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && advance |=> r_out.press_count == $past(tick_result.press_count))
        else $error("result press count differs from tick logic");

endmodule

// ===== rtl/bpq_tick.sv =====
// Per-tick debounce, press counter and short/long press toggle state.
module bpq_tick
    import bpq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_tick,
    input  logic    i_pin,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [8:0]  r_since,   n_since;
    logic [16:0] r_held,    n_held;
    logic        r_sampled, n_sampled;
    logic        r_prev,    n_prev;
    logic        r_long_gate,  n_long_gate;
    logic        r_long_state, n_long_state;
    logic        r_logic_state, n_logic_state;
    logic [7:0]  r_count,   n_count;
    logic [8:0]  since_inc;
    logic [16:0] held_inc;
    logic        sample;

    // Advance the timers, then sample once the debounce interval is exceeded
    always_comb begin
        since_inc = (r_since < SINCE_MAX) ? r_since + 9'd1 : r_since;
        held_inc  = (r_held < HELD_MAX) ? r_held + 17'd1 : r_held;
        sample    = since_inc > {1'b0, i_cfg.debounce_interval};

        n_since       = since_inc;
        n_held        = held_inc;
        n_sampled     = r_sampled;
        n_prev        = r_prev;
        n_long_gate   = r_long_gate;
        n_long_state  = r_long_state;
        n_logic_state = r_logic_state;
        n_count       = r_count;

        if (sample) begin
            n_sampled = i_pin;
            n_prev    = i_pin;
            n_since   = '0;
            if (i_pin == LEVEL_PRESSED && r_prev == LEVEL_RELEASED) begin
                // New press: restart the hold timer and count it
                n_held  = '0;
                n_count = (r_count < i_cfg.max_count) ? r_count + 8'd1 : '0;
            end else if (i_pin == LEVEL_PRESSED && r_prev == LEVEL_PRESSED) begin
                // Held past the long-press time: toggle once per hold
                if (held_inc > {1'b0, i_cfg.long_press_time}) begin
                    if (r_long_gate) begin
                        n_long_state = ~r_long_state;
                    end
                    n_long_gate = 1'b0;
                end
            end else if (i_pin == LEVEL_RELEASED && r_prev == LEVEL_PRESSED) begin
                // Release: short-press toggle unless a long press fired
                if (r_long_gate) begin
                    n_logic_state = ~r_logic_state;
                end
                n_long_gate = 1'b1;
            end
        end
    end

    // Hold the state, update only on a tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since       <= '0;
            r_held        <= '0;
            r_sampled     <= LEVEL_RELEASED;
            r_prev        <= LEVEL_RELEASED;
            r_long_gate   <= 1'b1;
            r_long_state  <= 1'b0;
            r_logic_state <= 1'b0;
            r_count       <= '0;
        end else if (i_tick) begin
            r_since       <= n_since;
            r_held        <= n_held;
            r_sampled     <= n_sampled;
            r_prev        <= n_prev;
            r_long_gate   <= n_long_gate;
            r_long_state  <= n_long_state;
            r_logic_state <= n_logic_state;
            r_count       <= n_count;
        end
    end

    // Result as seen after this tick's update
    assign o_result.debounced_level = n_sampled;
    assign o_result.logic_flag      = n_logic_state;
    assign o_result.long_flag       = n_long_state;
    assign o_result.press_count     = n_count;

endmodule
